[sv/jpts_pkg.sv]
`default_nettype none
package jpts_pkg;

  localparam int unsigned ANGLE_W  = 7;
  localparam int unsigned VALUE_W  = 16;
  localparam int unsigned ERR_W    = VALUE_W + 1;
  localparam int unsigned ENTRY_W  = 2 * VALUE_W;
  localparam int unsigned LEG_W    = 3;
  localparam int unsigned CFG_IDX_W = 2;

  localparam int unsigned DEFAULT_POSE = 42;

  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_SOLVE = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_TARGET_HEIGHT   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SEARCH_RADIUS   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_START_TOLERANCE = 2'd2;

  // Scan window handed from the control FSM to the scan engine.
  typedef struct packed {
    logic               start;
    logic [ANGLE_W-1:0] knee_lo;
    logic [ANGLE_W-1:0] knee_hi;
    logic [ANGLE_W-1:0] ankle_lo;
    logic [ANGLE_W-1:0] ankle_hi;
  } scan_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } scan_status_t;

endpackage
`default_nettype wire

[sv/jpts_ram.sv]
`default_nettype none
module jpts_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 8281
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule
`default_nettype wire

[sv/jpts_scan.sv]
`default_nettype none
module jpts_scan #(
  parameter int unsigned ANGLE_COUNT = 91
) (
  input  wire logic                                   clk_i,
  input  wire logic                                   rst_ni,
  input  wire jpts_pkg::scan_req_t                    req_i,
  input  wire logic signed [jpts_pkg::VALUE_W-1:0]    want_i,
  input  wire logic signed [jpts_pkg::VALUE_W-1:0]    target_height_i,
  input  wire logic [jpts_pkg::VALUE_W-2:0]           tolerance_i,
  input  wire logic [jpts_pkg::ENTRY_W-1:0]           rdata_i,
  output logic                                        re_o,
  output logic [$clog2(ANGLE_COUNT*ANGLE_COUNT)-1:0]  raddr_o,
  output jpts_pkg::scan_status_t                      status_o,
  output logic [jpts_pkg::ANGLE_W-1:0]                best_knee_o,
  output logic [jpts_pkg::ANGLE_W-1:0]                best_ankle_o,
  output logic                                        found_o
);

  localparam int unsigned MW  = $clog2(ANGLE_COUNT * ANGLE_COUNT);
  localparam int unsigned DEF = (jpts_pkg::DEFAULT_POSE < ANGLE_COUNT - 1) ?
                                jpts_pkg::DEFAULT_POSE : ANGLE_COUNT - 1;
  localparam int unsigned AW  = jpts_pkg::ANGLE_W;
  localparam int unsigned EW  = jpts_pkg::ERR_W;
  localparam int unsigned VW  = jpts_pkg::VALUE_W;

  logic [AW-1:0] knee_q, knee_d, ankle_q, ankle_d;
  logic [AW-1:0] ankle_lo_q, knee_hi_q, ankle_hi_q;
  logic          issue_q, issue_d;
  logic          row_end, last_issue;

  logic          cmp_v_q, cmp_last_q;
  logic [AW-1:0] cmp_knee_q, cmp_ankle_q;

  logic [EW-1:0] best_h_q, best_h_d, best_r_q, best_r_d;
  logic [AW-1:0] best_k_q, best_k_d, best_a_q, best_a_d;
  logic          found_q, found_d;

  logic [EW-1:0] diff_h, diff_r, err_h, err_r;
  logic          take;

  assign row_end    = (ankle_q == ankle_hi_q);
  assign last_issue = issue_q && row_end && (knee_q == knee_hi_q);

  always_comb begin
    knee_d  = knee_q;
    ankle_d = ankle_q;
    issue_d = issue_q;
    if (req_i.start) begin
      knee_d  = req_i.knee_lo;
      ankle_d = req_i.ankle_lo;
      issue_d = 1'b1;
    end else if (issue_q) begin
      if (row_end) begin
        ankle_d = ankle_lo_q;
        if (knee_q == knee_hi_q) begin
          issue_d = 1'b0;
        end else begin
          knee_d = knee_q + AW'(1);
        end
      end else begin
        ankle_d = ankle_q + AW'(1);
      end
    end
  end

  assign re_o    = issue_q;
  assign raddr_o = MW'(knee_q * ANGLE_COUNT) + MW'(ankle_q);

  // Exact 17-bit magnitudes of both errors; height sits in the low half of a word.
  always_comb begin
    diff_h = {target_height_i[VW-1], target_height_i} -
             {rdata_i[VW-1], rdata_i[VW-1:0]};
    diff_r = {want_i[VW-1], want_i} - {rdata_i[2*VW-1], rdata_i[2*VW-1:VW]};
    err_h  = diff_h[EW-1] ? (~diff_h + EW'(1)) : diff_h;
    err_r  = diff_r[EW-1] ? (~diff_r + EW'(1)) : diff_r;
    take   = cmp_v_q && (err_h < best_h_q) && (err_r < best_r_q);
  end

  always_comb begin
    best_h_d = best_h_q;
    best_r_d = best_r_q;
    best_k_d = best_k_q;
    best_a_d = best_a_q;
    found_d  = found_q;
    if (req_i.start) begin
      best_h_d = EW'(tolerance_i);
      best_r_d = EW'(tolerance_i);
      best_k_d = AW'(DEF);
      best_a_d = AW'(DEF);
      found_d  = 1'b0;
    end else if (take) begin
      best_h_d = err_h;
      best_r_d = err_r;
      best_k_d = cmp_knee_q;
      best_a_d = cmp_ankle_q;
      found_d  = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      issue_q    <= 1'b0;
      cmp_v_q    <= 1'b0;
      cmp_last_q <= 1'b0;
      found_q    <= 1'b0;
    end else begin
      issue_q    <= issue_d;
      cmp_v_q    <= issue_q;
      cmp_last_q <= last_issue;
      found_q    <= found_d;
    end
  end

  always_ff @(posedge clk_i) begin
    knee_q      <= knee_d;
    ankle_q     <= ankle_d;
    cmp_knee_q  <= knee_q;
    cmp_ankle_q <= ankle_q;
    best_h_q    <= best_h_d;
    best_r_q    <= best_r_d;
    best_k_q    <= best_k_d;
    best_a_q    <= best_a_d;
    if (req_i.start) begin
      ankle_lo_q <= req_i.ankle_lo;
      knee_hi_q  <= req_i.knee_hi;
      ankle_hi_q <= req_i.ankle_hi;
    end
  end

  assign status_o.busy = issue_q || cmp_v_q;
  assign status_o.done = cmp_v_q && cmp_last_q;
  assign best_knee_o   = best_k_q;
  assign best_ankle_o  = best_a_q;
  assign found_o       = found_q;

  property p_done_ends_scan;
    @(posedge clk_i) disable iff (!rst_ni) status_o.done |=> !cmp_v_q;
  endproperty
  a_done_ends_scan: assert property (p_done_ends_scan)
    else $error("scan kept comparing after its last entry");

  property p_issue_in_window;
    @(posedge clk_i) disable iff (!rst_ni)
      issue_q |-> (ankle_q <= ankle_hi_q) && (knee_q <= knee_hi_q);
  endproperty
  a_issue_in_window: assert property (p_issue_in_window)
    else $error("scan address left its window");

  property p_best_in_table;
    @(posedge clk_i) disable iff (!rst_ni)
      found_q |-> (best_k_q < ANGLE_COUNT) && (best_a_q < ANGLE_COUNT);
  endproperty
  a_best_in_table: assert property (p_best_in_table)
    else $error("best pose outside the table");

endmodule
`default_nettype wire

[sv/joint_pose_tracking_search_core.sv]
// Joint pose tracking search core.
// Input channel (in_valid_i/in_ready_o) carries load and solve beats. A load
// beat writes one reach/height entry into the table memory in the cycle it is
// accepted and gives no result; out-of-range indexes are dropped. A solve beat
// for a leg at or beyond LEG_COUNT is dropped as well.
// A solve scans the table one memory read per cycle, knee outer, ankle inner,
// through a registered read and a compare stage. A leg's first solve reads all
// ANGLE_COUNT*ANGLE_COUNT entries (8281 at the default); later solves
// read the window of +-search_radius around the leg's pose, clipped to the
// table, at most (2*radius+1)^2 entries (961 at the default radius). A solve
// goes through a setup step, the reads, a compare step and a finish step that
// raises the result beat and waits for a free output register. Only one
// item is in work at a time; in_ready_o is high while no solve is in progress.
// The result sits in an output register (out_valid_o/out_ready_i). If the
// receiver stalls, the next item is still accepted; a solve that finishes
// before the register frees waits there without losing its result.
// Config writes (cfg_we_i) take effect the next cycle; the user makes them only
// while idle, as the core does not enforce it. Reset restores the register
// defaults and forgets leg poses; the uncleared table is undefined until loaded.
`default_nettype none
module joint_pose_tracking_search_core #(
  parameter int unsigned ANGLE_COUNT = 91,
  parameter int unsigned LEG_COUNT   = 8
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 cfg_we_i,
  input  wire logic [jpts_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  wire logic [jpts_pkg::VALUE_W-1:0]         cfg_wdata_i,
  input  wire logic                                 in_valid_i,
  output logic                                      in_ready_o,
  input  wire logic                                 cmd_i,
  input  wire logic [jpts_pkg::ANGLE_W-1:0]         entry_knee_i,
  input  wire logic [jpts_pkg::ANGLE_W-1:0]         entry_ankle_i,
  input  wire logic signed [jpts_pkg::VALUE_W-1:0]  entry_reach_i,
  input  wire logic signed [jpts_pkg::VALUE_W-1:0]  entry_height_i,
  input  wire logic [jpts_pkg::LEG_W-1:0]           leg_i,
  input  wire logic signed [jpts_pkg::VALUE_W-1:0]  wanted_reach_i,
  output logic                                      out_valid_o,
  input  wire logic                                 out_ready_i,
  output logic [jpts_pkg::LEG_W-1:0]                out_leg_o,
  output logic [jpts_pkg::ANGLE_W-1:0]              knee_angle_o,
  output logic [jpts_pkg::ANGLE_W-1:0]              ankle_angle_o,
  output logic                                      match_found_o
);

  localparam int unsigned DEPTH = ANGLE_COUNT * ANGLE_COUNT;
  localparam int unsigned MW    = $clog2(DEPTH);
  localparam int unsigned LI    = (LEG_COUNT > 1) ? $clog2(LEG_COUNT) : 1;
  localparam int unsigned AW    = jpts_pkg::ANGLE_W;
  localparam int unsigned VW    = jpts_pkg::VALUE_W;
  localparam int unsigned WW    = AW + 2;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SETUP = 2'd1;
  localparam logic [1:0] S_SCAN  = 2'd2;
  localparam logic [1:0] S_DONE  = 2'd3;

  logic [1:0] state_q, state_d;

  logic signed [VW-1:0] target_height_q;
  logic [AW-1:0]        search_radius_q;
  logic [VW-2:0]        start_tolerance_q;

  logic [AW-1:0] leg_knee_q  [LEG_COUNT];
  logic [AW-1:0] leg_ankle_q [LEG_COUNT];
  logic [LEG_COUNT-1:0] leg_known_q;

  logic [jpts_pkg::LEG_W-1:0] leg_q;
  logic signed [VW-1:0]       want_q;
  logic [LI-1:0]              leg_idx;

  logic       in_fire, load_fire, solve_fire, load_ok, leg_ok, out_free, finish;
  logic       ram_we;
  logic [MW-1:0] ram_waddr;

  logic          ram_re;
  logic [MW-1:0] ram_raddr;
  logic [jpts_pkg::ENTRY_W-1:0] ram_rdata;

  jpts_pkg::scan_req_t    scan_req;
  jpts_pkg::scan_status_t scan_st;
  logic [AW-1:0] best_knee, best_ankle;
  logic          found;

  logic signed [WW-1:0] k_lo, k_hi, a_lo, a_hi;
  logic [AW-1:0] cur_knee, cur_ankle, new_knee, new_ankle;

  assign in_ready_o = (state_q == S_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign load_ok    = (8'(entry_knee_i) < 8'(ANGLE_COUNT)) &&
                      (8'(entry_ankle_i) < 8'(ANGLE_COUNT));
  assign leg_ok     = (5'(leg_i) < 5'(LEG_COUNT));
  assign load_fire  = in_fire && (cmd_i == jpts_pkg::CMD_LOAD);
  assign solve_fire = in_fire && (cmd_i == jpts_pkg::CMD_SOLVE) && leg_ok;
  assign out_free   = !out_valid_o || out_ready_i;
  assign finish     = (state_q == S_DONE) && out_free;

  assign ram_we    = load_fire && load_ok;
  assign ram_waddr = MW'(entry_knee_i * ANGLE_COUNT) + MW'(entry_ankle_i);

  jpts_ram #(
    .WIDTH (jpts_pkg::ENTRY_W),
    .DEPTH (DEPTH)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i ({entry_reach_i, entry_height_i}),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign leg_idx   = LI'(leg_q);
  assign cur_knee  = leg_knee_q[leg_idx];
  assign cur_ankle = leg_ankle_q[leg_idx];

  // Window around the last pose, clipped to the table edges.
  always_comb begin
    k_lo = WW'(cur_knee) - WW'(search_radius_q);
    k_hi = WW'(cur_knee) + WW'(search_radius_q);
    a_lo = WW'(cur_ankle) - WW'(search_radius_q);
    a_hi = WW'(cur_ankle) + WW'(search_radius_q);
    if (k_lo < 0) k_lo = '0;
    if (a_lo < 0) a_lo = '0;
    if (k_hi > WW'(ANGLE_COUNT - 1)) k_hi = WW'(ANGLE_COUNT - 1);
    if (a_hi > WW'(ANGLE_COUNT - 1)) a_hi = WW'(ANGLE_COUNT - 1);
  end

  always_comb begin
    scan_req.start = (state_q == S_SETUP);
    if (leg_known_q[leg_idx]) begin
      scan_req.knee_lo  = k_lo[AW-1:0];
      scan_req.knee_hi  = k_hi[AW-1:0];
      scan_req.ankle_lo = a_lo[AW-1:0];
      scan_req.ankle_hi = a_hi[AW-1:0];
    end else begin
      scan_req.knee_lo  = '0;
      scan_req.knee_hi  = AW'(ANGLE_COUNT - 1);
      scan_req.ankle_lo = '0;
      scan_req.ankle_hi = AW'(ANGLE_COUNT - 1);
    end
  end

  jpts_scan #(
    .ANGLE_COUNT (ANGLE_COUNT)
  ) u_scan (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .req_i           (scan_req),
    .want_i          (want_q),
    .target_height_i (target_height_q),
    .tolerance_i     (start_tolerance_q),
    .rdata_i         (ram_rdata),
    .re_o            (ram_re),
    .raddr_o         (ram_raddr),
    .status_o        (scan_st),
    .best_knee_o     (best_knee),
    .best_ankle_o    (best_ankle),
    .found_o         (found)
  );

  always_comb begin
    if (!leg_known_q[leg_idx]) begin
      new_knee  = best_knee;
      new_ankle = best_ankle;
    end else begin
      new_knee  = cur_knee;
      new_ankle = cur_ankle;
      if (best_knee > cur_knee) new_knee = cur_knee + AW'(1);
      else if (best_knee < cur_knee) new_knee = cur_knee - AW'(1);
      if (best_ankle > cur_ankle) new_ankle = cur_ankle + AW'(1);
      else if (best_ankle < cur_ankle) new_ankle = cur_ankle - AW'(1);
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:  if (solve_fire) state_d = S_SETUP;
      S_SETUP: state_d = S_SCAN;
      S_SCAN:  if (scan_st.done) state_d = S_DONE;
      S_DONE:  if (out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q           <= S_IDLE;
      target_height_q   <= 16'sd1200;
      search_radius_q   <= 7'd15;
      start_tolerance_q <= 15'd800;
      leg_known_q       <= '0;
      out_valid_o       <= 1'b0;
      for (int i = 0; i < LEG_COUNT; i++) begin
        leg_knee_q[i]  <= '0;
        leg_ankle_q[i] <= '0;
      end
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          jpts_pkg::CFG_TARGET_HEIGHT:   target_height_q   <= cfg_wdata_i;
          jpts_pkg::CFG_SEARCH_RADIUS:   search_radius_q   <= cfg_wdata_i[AW-1:0];
          jpts_pkg::CFG_START_TOLERANCE: start_tolerance_q <= cfg_wdata_i[VW-2:0];
          default: ;
        endcase
      end
      if (finish) begin
        leg_knee_q[leg_idx]  <= new_knee;
        leg_ankle_q[leg_idx] <= new_ankle;
        leg_known_q[leg_idx] <= 1'b1;
        out_valid_o          <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_o <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (solve_fire) begin
      leg_q  <= leg_i;
      want_q <= wanted_reach_i;
    end
    if (finish) begin
      out_leg_o     <= leg_q;
      knee_angle_o  <= new_knee;
      ankle_angle_o <= new_ankle;
      match_found_o <= found;
    end
  end

  property p_done_in_scan;
    @(posedge clk_i) disable iff (!rst_ni) scan_st.done |-> (state_q == S_SCAN);
  endproperty
  a_done_in_scan: assert property (p_done_in_scan)
    else $error("scan finished outside the scan state");

  property p_no_write_during_scan;
    @(posedge clk_i) disable iff (!rst_ni) ram_we |-> !scan_st.busy;
  endproperty
  a_no_write_during_scan: assert property (p_no_write_during_scan)
    else $error("table written while a scan reads it");

  property p_result_from_done;
    @(posedge clk_i) disable iff (!rst_ni)
      $rose(out_valid_o) |-> ($past(state_q) == S_DONE);
  endproperty
  a_result_from_done: assert property (p_result_from_done)
    else $error("result beat raised outside the finish step");

  property p_pose_in_table;
    @(posedge clk_i) disable iff (!rst_ni)
      out_valid_o |-> (knee_angle_o < ANGLE_COUNT) && (ankle_angle_o < ANGLE_COUNT);
  endproperty
  a_pose_in_table: assert property (p_pose_in_table)
    else $error("result pose outside the table");

endmodule
`default_nettype wire

[test/pose_checker.sv]
`default_nettype none
module pose_checker #(
  parameter int unsigned ANGLE_COUNT = 91,
  parameter int unsigned LEG_COUNT   = 8
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                cfg_we_i,
  input  wire logic [jpts_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  wire logic [jpts_pkg::VALUE_W-1:0]        cfg_wdata_i,
  input  wire logic                                in_valid_i,
  input  wire logic                                in_ready_i,
  input  wire logic                                cmd_i,
  input  wire logic [jpts_pkg::ANGLE_W-1:0]        entry_knee_i,
  input  wire logic [jpts_pkg::ANGLE_W-1:0]        entry_ankle_i,
  input  wire logic signed [jpts_pkg::VALUE_W-1:0] entry_reach_i,
  input  wire logic signed [jpts_pkg::VALUE_W-1:0] entry_height_i,
  input  wire logic [jpts_pkg::LEG_W-1:0]          leg_i,
  input  wire logic signed [jpts_pkg::VALUE_W-1:0] wanted_reach_i,
  input  wire logic                                out_valid_i,
  input  wire logic                                out_ready_i,
  input  wire logic [jpts_pkg::LEG_W-1:0]          out_leg_i,
  input  wire logic [jpts_pkg::ANGLE_W-1:0]        knee_angle_i,
  input  wire logic [jpts_pkg::ANGLE_W-1:0]        ankle_angle_i,
  input  wire logic                                match_found_i,
  output int                                       pending_o,
  output int                                       fail_count_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CELLS      = ANGLE_COUNT * ANGLE_COUNT;
  localparam int REST_POSE  = (jpts_pkg::DEFAULT_POSE < ANGLE_COUNT - 1) ?
                              jpts_pkg::DEFAULT_POSE : ANGLE_COUNT - 1;
  localparam int RESET_TARGET_HEIGHT   = 1200;
  localparam int RESET_SEARCH_RADIUS   = 15;
  localparam int RESET_START_TOLERANCE = 800;

  typedef struct packed {
    logic [jpts_pkg::LEG_W-1:0]   leg;
    logic [jpts_pkg::ANGLE_W-1:0] knee;
    logic [jpts_pkg::ANGLE_W-1:0] ankle;
    logic                         found;
  } pose_t;

  logic signed [jpts_pkg::VALUE_W-1:0] reach_tab  [CELLS];
  logic signed [jpts_pkg::VALUE_W-1:0] height_tab [CELLS];
  int    pose_knee  [LEG_COUNT];
  int    pose_ankle [LEG_COUNT];
  bit    pose_known [LEG_COUNT];
  int    target_height;
  int    search_radius;
  int    start_tolerance;
  pose_t pose_q[$];
  int    mismatches = 0;

  assign fail_count_o = mismatches;

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("%0t pose_checker: %s: got %0d, expected %0d", $realtime, what, got, want);
    mismatches++;
  endtask

  // Scans the full table on a leg's first solve, otherwise the clipped window
  // around its pose, and updates the tracked pose the way the core does.
  function automatic pose_t solve_pose(input int leg, input int want);
    int    klo, khi, alo, ahi, k, a, slot;
    int    best_r, best_h, best_k, best_a, eh, er;
    logic  hit;
    pose_t res;
    klo = 0;
    khi = ANGLE_COUNT - 1;
    alo = 0;
    ahi = ANGLE_COUNT - 1;
    if (pose_known[leg]) begin
      klo = pose_knee[leg] - search_radius;
      khi = pose_knee[leg] + search_radius;
      alo = pose_ankle[leg] - search_radius;
      ahi = pose_ankle[leg] + search_radius;
      if (klo < 0) klo = 0;
      if (alo < 0) alo = 0;
      if (khi > ANGLE_COUNT - 1) khi = ANGLE_COUNT - 1;
      if (ahi > ANGLE_COUNT - 1) ahi = ANGLE_COUNT - 1;
    end
    best_r = start_tolerance;
    best_h = start_tolerance;
    best_k = REST_POSE;
    best_a = REST_POSE;
    hit = 1'b0;
    for (k = klo; k <= khi; k++) begin
      for (a = alo; a <= ahi; a++) begin
        slot = k * ANGLE_COUNT + a;
        eh = target_height - int'(height_tab[slot]);
        er = want - int'(reach_tab[slot]);
        if (eh < 0) eh = -eh;
        if (er < 0) er = -er;
        if (eh < best_h && er < best_r) begin
          best_h = eh;
          best_r = er;
          best_k = k;
          best_a = a;
          hit = 1'b1;
        end
      end
    end
    if (!pose_known[leg]) begin
      pose_knee[leg]  = best_k;
      pose_ankle[leg] = best_a;
      pose_known[leg] = 1'b1;
    end else begin
      if (best_k > pose_knee[leg]) pose_knee[leg]++;
      else if (best_k < pose_knee[leg]) pose_knee[leg]--;
      if (best_a > pose_ankle[leg]) pose_ankle[leg]++;
      else if (best_a < pose_ankle[leg]) pose_ankle[leg]--;
    end
    res.leg   = jpts_pkg::LEG_W'(leg);
    res.knee  = jpts_pkg::ANGLE_W'(pose_knee[leg]);
    res.ankle = jpts_pkg::ANGLE_W'(pose_ankle[leg]);
    res.found = hit;
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    pose_t exp_pose;
    int    slot;
    if (!rst_ni) begin
      target_height   = RESET_TARGET_HEIGHT;
      search_radius   = RESET_SEARCH_RADIUS;
      start_tolerance = RESET_START_TOLERANCE;
      for (int i = 0; i < LEG_COUNT; i++) begin
        pose_knee[i]  = 0;
        pose_ankle[i] = 0;
        pose_known[i] = 1'b0;
      end
      pose_q.delete();
      pending_o <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          jpts_pkg::CFG_TARGET_HEIGHT:
            target_height = int'($signed(cfg_wdata_i));
          jpts_pkg::CFG_SEARCH_RADIUS:
            search_radius = int'(cfg_wdata_i[jpts_pkg::ANGLE_W-1:0]);
          jpts_pkg::CFG_START_TOLERANCE:
            start_tolerance = int'(cfg_wdata_i[jpts_pkg::VALUE_W-2:0]);
          default: ;
        endcase
      end
      if (out_valid_i && out_ready_i) begin
        if (pose_q.size() == 0) begin
          report_mismatch("result beat with no solve pending", 1, 0);
        end else begin
          exp_pose = pose_q.pop_front();
          if (out_leg_i !== exp_pose.leg)
            report_mismatch("out_leg", int'(out_leg_i), int'(exp_pose.leg));
          if (knee_angle_i !== exp_pose.knee)
            report_mismatch("knee_angle", int'(knee_angle_i), int'(exp_pose.knee));
          if (ankle_angle_i !== exp_pose.ankle)
            report_mismatch("ankle_angle", int'(ankle_angle_i), int'(exp_pose.ankle));
          if (match_found_i !== exp_pose.found)
            report_mismatch("match_found", int'(match_found_i), int'(exp_pose.found));
        end
      end
      if (in_valid_i && in_ready_i) begin
        if (cmd_i == jpts_pkg::CMD_LOAD) begin
          if (entry_knee_i < ANGLE_COUNT && entry_ankle_i < ANGLE_COUNT) begin
            slot = int'(entry_knee_i) * ANGLE_COUNT + int'(entry_ankle_i);
            reach_tab[slot]  = entry_reach_i;
            height_tab[slot] = entry_height_i;
          end
        end else if (leg_i < LEG_COUNT) begin
          pose_q.push_back(solve_pose(int'(leg_i), int'(wanted_reach_i)));
        end
      end
      pending_o <= pose_q.size();
    end
  end

endmodule
`default_nettype wire

[test/tb_joint_pose_tracking_search_core.sv]
`default_nettype none
module tb_joint_pose_tracking_search_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ANGLES       = 91;
  localparam int LEGS         = 8;
  localparam int RANDOM_ITEMS = 100;
  localparam int DRAIN_LIMIT  = 200_000;
  localparam int SETTLE       = 20;

  logic                                clk       = 1'b0;
  logic                                rst_n     = 1'b0;
  logic                                cfg_we    = 1'b0;
  logic [jpts_pkg::CFG_IDX_W-1:0]      cfg_index = '0;
  logic [jpts_pkg::VALUE_W-1:0]        cfg_wdata = '0;
  logic                                in_valid  = 1'b0;
  logic                                in_ready;
  logic                                cmd       = jpts_pkg::CMD_LOAD;
  logic [jpts_pkg::ANGLE_W-1:0]        entry_knee   = '0;
  logic [jpts_pkg::ANGLE_W-1:0]        entry_ankle  = '0;
  logic signed [jpts_pkg::VALUE_W-1:0] entry_reach  = '0;
  logic signed [jpts_pkg::VALUE_W-1:0] entry_height = '0;
  logic [jpts_pkg::LEG_W-1:0]          leg          = '0;
  logic signed [jpts_pkg::VALUE_W-1:0] wanted_reach = '0;
  logic                                out_valid;
  logic                                out_ready = 1'b0;
  logic [jpts_pkg::LEG_W-1:0]          out_leg;
  logic [jpts_pkg::ANGLE_W-1:0]        knee_angle;
  logic [jpts_pkg::ANGLE_W-1:0]        ankle_angle;
  logic                                match_found;
  int                                  pending;
  int                                  fail_count;

  int send_idle_pct = 22;
  int recv_idle_pct = 61;
  int cur_target    = 1200;
  int random_done   = 0;

  always #1 clk = ~clk;

  always @(posedge clk) out_ready <= rst_n && ($urandom_range(99) >= recv_idle_pct);

  joint_pose_tracking_search_core #(
    .ANGLE_COUNT(ANGLES),
    .LEG_COUNT  (LEGS)
  ) u_dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg_we_i      (cfg_we),
    .cfg_index_i   (cfg_index),
    .cfg_wdata_i   (cfg_wdata),
    .in_valid_i    (in_valid),
    .in_ready_o    (in_ready),
    .cmd_i         (cmd),
    .entry_knee_i  (entry_knee),
    .entry_ankle_i (entry_ankle),
    .entry_reach_i (entry_reach),
    .entry_height_i(entry_height),
    .leg_i         (leg),
    .wanted_reach_i(wanted_reach),
    .out_valid_o   (out_valid),
    .out_ready_i   (out_ready),
    .out_leg_o     (out_leg),
    .knee_angle_o  (knee_angle),
    .ankle_angle_o (ankle_angle),
    .match_found_o (match_found)
  );

  pose_checker #(
    .ANGLE_COUNT(ANGLES),
    .LEG_COUNT  (LEGS)
  ) u_checker (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg_we_i      (cfg_we),
    .cfg_index_i   (cfg_index),
    .cfg_wdata_i   (cfg_wdata),
    .in_valid_i    (in_valid),
    .in_ready_i    (in_ready),
    .cmd_i         (cmd),
    .entry_knee_i  (entry_knee),
    .entry_ankle_i (entry_ankle),
    .entry_reach_i (entry_reach),
    .entry_height_i(entry_height),
    .leg_i         (leg),
    .wanted_reach_i(wanted_reach),
    .out_valid_i   (out_valid),
    .out_ready_i   (out_ready),
    .out_leg_i     (out_leg),
    .knee_angle_i  (knee_angle),
    .ankle_angle_i (ankle_angle),
    .match_found_i (match_found),
    .pending_o     (pending),
    .fail_count_o  (fail_count)
  );

  // Holds the beat until the core takes it; an idle gap drops valid first.
  task automatic send_item(input logic c, input int k, input int a, input int r,
                           input int h, input int lg, input int w);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    cmd          <= c;
    entry_knee   <= jpts_pkg::ANGLE_W'(k);
    entry_ankle  <= jpts_pkg::ANGLE_W'(a);
    entry_reach  <= jpts_pkg::VALUE_W'(r);
    entry_height <= jpts_pkg::VALUE_W'(h);
    leg          <= jpts_pkg::LEG_W'(lg);
    wanted_reach <= jpts_pkg::VALUE_W'(w);
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic load_cell(input int k, input int a, input int r, input int h);
    send_item(jpts_pkg::CMD_LOAD, k, a, r, h, $urandom_range(LEGS - 1), int'($urandom));
  endtask

  task automatic solve_leg(input int lg, input int w);
    send_item(jpts_pkg::CMD_SOLVE, $urandom_range(127), $urandom_range(127),
              int'($urandom), int'($urandom), lg, w);
  endtask

  task automatic wait_idle();
    int n;
    n = 0;
    in_valid <= 1'b0;
    do begin
      @(posedge clk);
      n++;
    end while ((pending != 0 || !in_ready) && n < DRAIN_LIMIT);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_config(input int height, input int radius, input int tol);
    cfg_we    <= 1'b1;
    cfg_index <= jpts_pkg::CFG_TARGET_HEIGHT;
    cfg_wdata <= jpts_pkg::VALUE_W'(height);
    @(posedge clk);
    cfg_index <= jpts_pkg::CFG_SEARCH_RADIUS;
    cfg_wdata <= jpts_pkg::VALUE_W'(radius);
    @(posedge clk);
    cfg_index <= jpts_pkg::CFG_START_TOLERANCE;
    cfg_wdata <= jpts_pkg::VALUE_W'(tol);
    @(posedge clk);
    cfg_we     <= 1'b0;
    cur_target = height;
  endtask

  // Heights cluster around the current target and reaches around zero so that
  // windowed scans find candidates; a share of beats uses full-range values.
  task automatic run_random(input int count);
    int k, a, r, h, w;
    for (int i = 0; i < count; i++) begin
      if (random_done < RANDOM_ITEMS / 3) begin
        send_idle_pct = 22;
        recv_idle_pct = 61;
      end else if (random_done < 2 * RANDOM_ITEMS / 3) begin
        send_idle_pct = 61;
        recv_idle_pct = 22;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      k = ($urandom_range(9) == 0) ? $urandom_range(127) : $urandom_range(ANGLES - 1);
      a = ($urandom_range(9) == 0) ? $urandom_range(127) : $urandom_range(ANGLES - 1);
      r = ($urandom_range(99) < 15) ? int'($urandom) : int'($urandom_range(6000)) - 3000;
      h = ($urandom_range(99) < 15) ? int'($urandom)
                                    : cur_target + int'($urandom_range(3000)) - 1500;
      w = ($urandom_range(99) < 15) ? int'($urandom) : int'($urandom_range(6000)) - 3000;
      if ($urandom_range(99) < 40) load_cell(k, a, r, h);
      else solve_leg($urandom_range(LEGS - 1), w);
      random_done++;
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    write_config(1200, 15, 800);

    // Every cell is written before the first solve reads the table.
    for (int k = 0; k < ANGLES; k++) begin
      for (int a = 0; a < ANGLES; a++) begin
        load_cell(k, a, int'($urandom_range(6000)) - 3000,
                  1200 + int'($urandom_range(3000)) - 1500);
      end
    end

    // Exact matches at both table corners, extreme values, and dropped loads.
    load_cell(0, 0, 20000, 1200);
    load_cell(ANGLES - 1, ANGLES - 1, -20000, 1200);
    load_cell(45, 46, 32767, -32768);
    load_cell(46, 45, -32768, 32767);
    load_cell(127, 127, 0, 1200);
    load_cell(ANGLES - 1, ANGLES, 0, 1200);
    load_cell(ANGLES, 0, 0, 1200);
    // First solve per leg; full-scale wanted reach finds nothing and lands
    // on the rest pose.
    solve_leg(0, 20000);
    solve_leg(1, -20000);
    solve_leg(2, 32767);
    solve_leg(3, -32768);
    solve_leg(4, 0);
    solve_leg(5, 1000);
    solve_leg(6, -1500);
    solve_leg(7, 2500);
    // Windowed solves next to the table edges and from the rest pose.
    solve_leg(0, 20000);
    solve_leg(1, 0);
    solve_leg(2, 0);
    solve_leg(3, -32768);
    solve_leg(0, -20000);

    wait_idle();
    write_config(-32768, 0, 32767);
    run_random(15);
    wait_idle();
    write_config(32767, ANGLES - 1, 0);
    run_random(6);
    wait_idle();
    write_config(1200, 3, 1500);
    run_random(30);
    wait_idle();
    write_config(int'($urandom_range(4000)) - 2000, $urandom_range(8, 1),
                 $urandom_range(4000, 200));
    run_random(25);
    wait_idle();
    write_config(1200, 15, 800);
    run_random(24);
    wait_idle();

    if (fail_count == 0 && pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule
`default_nettype wire
